>>> rtl/btr_pkg.sv
package btr_pkg;

	localparam int unsigned LEN_W     = 32;
	localparam int unsigned RATE_W    = 32;
	localparam int unsigned WIN_W     = 16;
	localparam int unsigned TIME_W    = 48;
	localparam int unsigned QUOTA_W   = 39;
	localparam int unsigned PROD_W    = RATE_W + WIN_W;

	localparam int unsigned CMD_DEPTH = 4;
	localparam int unsigned CMD_PW    = $clog2(CMD_DEPTH);
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_PW    = $clog2(RES_DEPTH);

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SEND = 2'd1,
		OP_RECV = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_GRANT = 2'd0,
		ST_BUSY  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [LEN_W-1:0] length;
	} cmd_t;

	typedef struct packed {
		logic             direction;
		status_t          status;
		logic [LEN_W-1:0] offset;
		logic [LEN_W-1:0] length;
		logic             last;
	} result_t;

	typedef struct packed {
		logic               load;
		logic [QUOTA_W-1:0] value;
	} quota_upd_t;

endpackage

>>> rtl/btr_quota.sv
module btr_quota #(
	parameter int unsigned TICKS_PER_SECOND = 1000
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [btr_pkg::RATE_W-1:0]    rate,
	input  logic [btr_pkg::WIN_W-1:0]     window,
	output btr_pkg::quota_upd_t           upd,
	output logic                          busy
);
	import btr_pkg::*;

	// quotient = floor(p * RECIP / 2^(PROD_W + SHIFT)) with RECIP rounded up,
	// exact for every PROD_W-bit product
	localparam int unsigned SHIFT  = $clog2(TICKS_PER_SECOND);
	localparam int unsigned DIG_W  = 16;
	localparam int unsigned STEPS  = 4;
	localparam int unsigned ACC_W  = PROD_W + DIG_W + 2;
	localparam int unsigned QSHIFT = PROD_W + SHIFT - DIG_W * (STEPS - 1);
	localparam logic [71:0] SCALE  = 72'd1 << (PROD_W + SHIFT);
	localparam logic [71:0] RECIP_X =
		(SCALE + 72'(TICKS_PER_SECOND) - 72'd1) / 72'(TICKS_PER_SECOND);
	localparam logic [DIG_W*STEPS-1:0] RECIP = RECIP_X[DIG_W*STEPS-1:0];

	typedef enum logic [1:0] {
		Q_IDLE,
		Q_MUL,
		Q_DONE
	} qstate_t;

	qstate_t                 state_q;
	logic [PROD_W-1:0]       prod_q;
	logic [ACC_W-1:0]        acc_q;
	logic [1:0]              step_q;
	quota_upd_t              upd_q;

	logic [DIG_W-1:0]        digit;
	logic [PROD_W+DIG_W-1:0] part;
	logic [ACC_W-1:0]        acc_next;
	logic [ACC_W-1:0]        quo;
	logic [QUOTA_W-1:0]      sat;

	// low digit first; bits shifted out are final
	always_comb begin
		digit    = RECIP[DIG_W*step_q +: DIG_W];
		part     = prod_q * digit;
		acc_next = (acc_q >> DIG_W) + ACC_W'(part);
		quo      = acc_q >> QSHIFT;
		sat      = (|quo[ACC_W-1:QUOTA_W]) ? '1 : quo[QUOTA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= Q_IDLE;
			prod_q      <= '0;
			acc_q       <= '0;
			step_q      <= '0;
			upd_q.load  <= 1'b0;
			upd_q.value <= '0;
		end else begin
			upd_q.load <= 1'b0;
			if (start) begin
				prod_q  <= PROD_W'(rate) * PROD_W'(window);
				acc_q   <= '0;
				step_q  <= '0;
				state_q <= Q_MUL;
			end else begin
				case (state_q)
					Q_MUL: begin
						acc_q  <= acc_next;
						step_q <= step_q + 1'b1;
						if (step_q == 2'(STEPS - 1)) begin
							state_q <= Q_DONE;
						end
					end
					Q_DONE: begin
						upd_q.value <= sat;
						upd_q.load  <= 1'b1;
						state_q     <= Q_IDLE;
					end
					default: begin
						state_q <= Q_IDLE;
					end
				endcase
			end
		end
	end

	assign upd  = upd_q;
	assign busy = start || (state_q != Q_IDLE);

endmodule

>>> rtl/btr_front.sv
module btr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [1:0]                 opcode,
	input  logic [btr_pkg::LEN_W-1:0]  request_length,
	input  logic                       hold,
	output logic                       full,
	output btr_pkg::cmd_t              cmd,
	output logic                       cmd_valid,
	input  logic                       cmd_pop
);
	import btr_pkg::*;

	cmd_t              mem_q [CMD_DEPTH];
	logic [CMD_PW-1:0] wr_q;
	logic [CMD_PW-1:0] rd_q;
	logic [CMD_PW:0]   cnt_q;

	logic accept;
	logic known_op;
	logic enq;
	logic deq;

	always_comb begin
		case (op_t'(opcode))
			OP_TICK, OP_SEND, OP_RECV: known_op = 1'b1;
			default:                   known_op = 1'b0;
		endcase
	end

	assign full      = (cnt_q == (CMD_PW+1)'(CMD_DEPTH)) || hold;
	assign accept    = push && !full;
	assign enq       = accept && known_op;
	assign cmd_valid = (cnt_q != '0);
	assign deq       = cmd_pop && cmd_valid;
	assign cmd       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_q] <= '{op: op_t'(opcode), length: request_length};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= wr_q + 1'b1;
			end
			if (deq) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (CMD_PW+1)'(enq) - (CMD_PW+1)'(deq);
		end
	end

endmodule

>>> rtl/btr_back.sv
module btr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  btr_pkg::cmd_t              cmd,
	input  logic                       cmd_valid,
	output logic                       cmd_pop,
	input  btr_pkg::quota_upd_t        upd [2],
	input  logic [btr_pkg::WIN_W-1:0]  window [2],
	input  logic                       room,
	output btr_pkg::result_t           res [2],
	output logic [1:0]                 res_cnt
);
	import btr_pkg::*;

	logic [TIME_W-1:0]  now_q;
	logic [QUOTA_W-1:0] left_q   [2];
	logic [TIME_W-1:0]  refill_q [2];
	logic [LEN_W-1:0]   pend_q   [2];
	logic [LEN_W-1:0]   pos_q    [2];
	logic               busy_q   [2];

	logic               fire;
	logic               is_tick;
	logic               req_dir;
	logic [TIME_W-1:0]  now_eff;

	logic [QUOTA_W-1:0] f      [2];
	logic               f_zero [2];
	logic               req_d  [2];
	logic               run    [2];
	logic [LEN_W-1:0]   pend_in[2];
	logic [LEN_W-1:0]   pos_in [2];
	logic               done1  [2];
	logic               done2  [2];
	logic               due    [2];
	logic               a_vld  [2];
	logic               b_vld  [2];
	logic               sp_vld [2];
	logic [QUOTA_W:0]   diff1  [2];
	logic [LEN_W-1:0]   g1     [2];
	logic [LEN_W-1:0]   g2     [2];
	logic [LEN_W-1:0]   pend1  [2];
	logic [LEN_W-1:0]   pos1   [2];
	result_t            sp     [2];
	result_t            ra     [2];
	result_t            rb     [2];
	result_t            c0     [2];
	result_t            c1     [2];
	logic [1:0]         cnt    [2];

	logic [QUOTA_W-1:0] left_n   [2];
	logic [TIME_W-1:0]  refill_n [2];
	logic [LEN_W-1:0]   pend_n   [2];
	logic [LEN_W-1:0]   pos_n    [2];
	logic               busy_n   [2];

	assign fire    = cmd_valid && room;
	assign cmd_pop = fire;
	assign is_tick = (cmd.op == OP_TICK);
	assign req_dir = (cmd.op == OP_RECV);
	assign now_eff = is_tick ? (now_q + TIME_W'(1)) : now_q;

	always_comb begin
		for (int d = 0; d < 2; d++) begin
			f[d]       = upd[d].value;
			f_zero[d]  = (f[d] == '0);
			req_d[d]   = !is_tick && (req_dir == 1'(d));
			pend_in[d] = req_d[d] ? cmd.length : pend_q[d];
			pos_in[d]  = req_d[d] ? '0 : pos_q[d];
			run[d]     = is_tick ? (busy_q[d] && !f_zero[d])
			           : (req_d[d] && !busy_q[d] && !f_zero[d] && (cmd.length != '0));

			// grant from what is left
			diff1[d] = (QUOTA_W+1)'(pend_in[d]) - (QUOTA_W+1)'(left_q[d]);
			done1[d] = (QUOTA_W'(pend_in[d]) <= left_q[d]);
			g1[d]    = done1[d] ? pend_in[d] : left_q[d][LEN_W-1:0];
			pend1[d] = done1[d] ? '0 : diff1[d][LEN_W-1:0];
			pos1[d]  = pos_in[d] + g1[d];
			a_vld[d] = run[d] && (left_q[d] != '0);

			// renewal and second grant
			due[d]   = ((now_eff - refill_q[d]) >= TIME_W'(window[d]));
			b_vld[d] = run[d] && !done1[d] && due[d];
			done2[d] = (QUOTA_W'(pend1[d]) <= f[d]);
			g2[d]    = done2[d] ? pend1[d] : f[d][LEN_W-1:0];

			ra[d].direction = 1'(d);
			ra[d].status    = ST_GRANT;
			ra[d].offset    = pos_in[d];
			ra[d].length    = g1[d];
			ra[d].last      = done1[d];

			rb[d].direction = 1'(d);
			rb[d].status    = ST_GRANT;
			rb[d].offset    = pos1[d];
			rb[d].length    = g2[d];
			rb[d].last      = done2[d];

			sp[d].direction = 1'(d);
			sp[d].status    = ST_GRANT;
			sp[d].offset    = '0;
			sp[d].length    = '0;
			sp[d].last      = 1'b1;
			sp_vld[d]       = 1'b1;
			if (is_tick && busy_q[d] && f_zero[d]) begin
				sp[d].offset = pos_q[d];
				sp[d].length = pend_q[d];
			end else if (req_d[d] && busy_q[d]) begin
				sp[d].status = ST_BUSY;
				sp[d].last   = 1'b0;
			end else if (req_d[d] && f_zero[d]) begin
				sp[d].length = cmd.length;
			end else if (req_d[d] && (cmd.length == '0)) begin
				sp[d].status = ST_EMPTY;
			end else begin
				sp_vld[d] = 1'b0;
			end

			left_n[d]   = left_q[d];
			refill_n[d] = refill_q[d];
			pend_n[d]   = pend_q[d];
			pos_n[d]    = pos_q[d];
			busy_n[d]   = busy_q[d];
			c0[d]       = sp[d];
			c1[d]       = rb[d];
			cnt[d]      = 2'd0;

			if (sp_vld[d]) begin
				cnt[d] = 2'd1;
				if (is_tick) begin
					pos_n[d]  = pos_q[d] + pend_q[d];
					pend_n[d] = '0;
					busy_n[d] = 1'b0;
				end
			end else if (run[d]) begin
				c0[d]  = a_vld[d] ? ra[d] : rb[d];
				cnt[d] = 2'(a_vld[d]) + 2'(b_vld[d]);
				if (b_vld[d]) begin
					left_n[d]   = f[d] - QUOTA_W'(g2[d]);
					refill_n[d] = now_eff;
					pend_n[d]   = pend1[d] - g2[d];
					pos_n[d]    = pos1[d] + g2[d];
					busy_n[d]   = !done2[d];
				end else begin
					left_n[d] = left_q[d] - QUOTA_W'(g1[d]);
					pend_n[d] = pend1[d];
					pos_n[d]  = pos1[d];
					busy_n[d] = !done1[d];
				end
			end
		end

		res[0]  = (cnt[0] != 2'd0) ? c0[0] : c0[1];
		res[1]  = (cnt[0] == 2'd2) ? c1[0] : ((cnt[0] == 2'd1) ? c0[1] : c1[1]);
		res_cnt = fire ? (cnt[0] + cnt[1]) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			for (int d = 0; d < 2; d++) begin
				left_q[d]   <= '0;
				refill_q[d] <= '0;
				pend_q[d]   <= '0;
				pos_q[d]    <= '0;
				busy_q[d]   <= 1'b0;
			end
		end else begin
			if (fire && is_tick) begin
				now_q <= now_eff;
			end
			for (int d = 0; d < 2; d++) begin
				if (fire) begin
					left_q[d]   <= left_n[d];
					refill_q[d] <= refill_n[d];
					pend_q[d]   <= pend_n[d];
					pos_q[d]    <= pos_n[d];
					busy_q[d]   <= busy_n[d];
				end
				// new quota restarts an idle direction
				if (upd[d].load && !busy_q[d]) begin
					left_q[d]   <= f[d];
					refill_q[d] <= now_q;
				end
			end
		end
	end

endmodule

>>> rtl/btr_out_fifo.sv
module btr_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  btr_pkg::result_t  res [2],
	input  logic [1:0]        res_cnt,
	output logic              room,
	input  logic              pop,
	output logic              empty,
	output btr_pkg::result_t  head
);
	import btr_pkg::*;

	result_t           mem_q [RES_DEPTH];
	logic [RES_PW-1:0] wr_q;
	logic [RES_PW-1:0] rd_q;
	logic [RES_PW:0]   cnt_q;
	logic              deq;

	assign room  = (cnt_q <= (RES_PW+1)'(RES_DEPTH - 2));
	assign empty = (cnt_q == '0);
	assign deq   = pop && !empty;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (res_cnt != 2'd0) begin
			mem_q[wr_q] <= res[0];
		end
		if (res_cnt == 2'd2) begin
			mem_q[wr_q + 1'b1] <= res[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + RES_PW'(res_cnt);
			if (deq) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (RES_PW+1)'(res_cnt) - (RES_PW+1)'(deq);
		end
	end

endmodule

>>> rtl/bytestream_rate_throttler_top.sv
// A result is written into the output queue as its transaction is taken.
// Throughput: one transaction per cycle while the output queue has room; a request
// yields up to two grants, which drain at one per pop.
// A register write recomputes that direction's quota (one multiply, four multiply-add
// steps, one load), and full stays high while it does so.
// Reset (arst_n low, asynchronous) empties both queues and clears time, quota and state.
module bytestream_rate_throttler_top #(
	parameter int unsigned TICKS_PER_SECOND = 1000
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                opcode,
	input  logic [btr_pkg::LEN_W-1:0] request_length,
	output logic                      empty,
	input  logic                      pop,
	output logic                      direction,
	output logic [1:0]                status,
	output logic [btr_pkg::LEN_W-1:0] chunk_offset,
	output logic [btr_pkg::LEN_W-1:0] chunk_length,
	output logic                      last,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [3:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import btr_pkg::*;

	localparam logic [1:0] REG_SEND_RATE   = 2'd0;
	localparam logic [1:0] REG_SEND_WINDOW = 2'd1;
	localparam logic [1:0] REG_RECV_RATE   = 2'd2;
	localparam logic [1:0] REG_RECV_WINDOW = 2'd3;

	logic [RATE_W-1:0] send_rate_q;
	logic [WIN_W-1:0]  send_win_q;
	logic [RATE_W-1:0] recv_rate_q;
	logic [WIN_W-1:0]  recv_win_q;
	logic              start_q [2];

	logic              wr_en;
	logic [1:0]        reg_idx;
	quota_upd_t        upd [2];
	logic              qbusy [2];
	logic [WIN_W-1:0]  win [2];
	cmd_t              cmd;
	logic              cmd_valid;
	logic              cmd_pop;
	logic              room;
	result_t           res [2];
	logic [1:0]        res_cnt;
	result_t           head;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_rate_q <= '0;
			send_win_q  <= WIN_W'(1);
			recv_rate_q <= '0;
			recv_win_q  <= WIN_W'(1);
			start_q[0]  <= 1'b0;
			start_q[1]  <= 1'b0;
		end else begin
			start_q[0] <= 1'b0;
			start_q[1] <= 1'b0;
			if (wr_en) begin
				case (reg_idx)
					REG_SEND_RATE: begin
						send_rate_q <= pwdata;
						start_q[0]  <= 1'b1;
					end
					REG_SEND_WINDOW: begin
						send_win_q <= pwdata[WIN_W-1:0];
						start_q[0] <= 1'b1;
					end
					REG_RECV_RATE: begin
						recv_rate_q <= pwdata;
						start_q[1]  <= 1'b1;
					end
					REG_RECV_WINDOW: begin
						recv_win_q <= pwdata[WIN_W-1:0];
						start_q[1] <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SEND_RATE:   prdata = send_rate_q;
			REG_SEND_WINDOW: prdata = 32'(send_win_q);
			REG_RECV_RATE:   prdata = recv_rate_q;
			REG_RECV_WINDOW: prdata = 32'(recv_win_q);
			default:         prdata = '0;
		endcase
	end

	assign win[0] = send_win_q;
	assign win[1] = recv_win_q;

	btr_quota #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_quota_send (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q[0]),
		.rate   (send_rate_q),
		.window (send_win_q),
		.upd    (upd[0]),
		.busy   (qbusy[0])
	);

	btr_quota #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_quota_recv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q[1]),
		.rate   (recv_rate_q),
		.window (recv_win_q),
		.upd    (upd[1]),
		.busy   (qbusy[1])
	);

	btr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.opcode         (opcode),
		.request_length (request_length),
		.hold           (qbusy[0] || qbusy[1]),
		.full           (full),
		.cmd            (cmd),
		.cmd_valid      (cmd_valid),
		.cmd_pop        (cmd_pop)
	);

	btr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.upd       (upd),
		.window    (win),
		.room      (room),
		.res       (res),
		.res_cnt   (res_cnt)
	);

	btr_out_fifo u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.res     (res),
		.res_cnt (res_cnt),
		.room    (room),
		.pop     (pop),
		.empty   (empty),
		.head    (head)
	);

	assign direction    = head.direction;
	assign status       = head.status;
	assign chunk_offset = head.offset;
	assign chunk_length = head.length;
	assign last         = head.last;

endmodule
